[src/cps_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the
// constellation point scaler. No dependencies; every other file uses it.
package cps_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 32;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Fixed field widths of the channels and the register.
   localparam int CMD_W    = 2;
   localparam int PIDX_W   = 6;
   localparam int UP_W     = 6;
   localparam int DATA_W   = 16;
   localparam int STATUS_W = 2;

   // Compare width that covers the index, the register and the point count.
   localparam int CMP_W = 8;

   // Products, energies and the square root operand.
   localparam int WIDE_W = 2 * DATA_W;
   localparam logic [WIDE_W-1:0] SQRT_FIRST_BIT = WIDE_W'(1) << (WIDE_W - 2);

   // Divider: one quotient bit per step.
   localparam int DIV_STEPS = DATA_W;
   localparam int DSTEP_W   = $clog2(DIV_STEPS);

   // Register port.
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = PADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_USED_POINTS = '0;

   // Saturation limits of a signed 16-bit result.
   localparam logic [DATA_W-1:0] POS_LIMIT = 16'h7FFF;
   localparam logic [DATA_W-1:0] NEG_LIMIT = 16'h8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE     = 2'd0,
      CMD_RECOMPUTE = 2'd1,
      CMD_MAP       = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_ZERO_AMP  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQ_I,
      MUL_SQ_Q,
      MUL_FS_I,
      MUL_FS_Q
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        in_ready;
      logic        tbl_write;
      logic        rd_scan;
      logic        rd_idx;
      logic        scan_clear;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        best_update;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        amp_load;
      logic        div_load;
      logic        div_step;
      logic        store_i;
      logic        store_q;
      logic        out_load;
      status_type  out_status;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    idx_in_table;
      logic    idx_lt_n;
      logic    amp_zero;
      logic    n_zero;
      logic    scan_done;
      logic    sqrt_last;
      logic    div_last;
      logic    out_free;
   } dp_stat_type;

endpackage

[src/cps_req_if.sv]
// Request channel of the constellation point scaler: valid/ready and one item.
// Depends on cps_pkg for the field widths.
interface cps_req_if;
   logic                               valid;
   logic                               ready;
   logic [cps_pkg::CMD_W-1:0]          cmd;
   logic [cps_pkg::PIDX_W-1:0]         point_index;
   logic signed [cps_pkg::DATA_W-1:0]  entry_i;
   logic signed [cps_pkg::DATA_W-1:0]  entry_q;
   logic [cps_pkg::DATA_W-1:0]         full_scale;

   modport source (
      output valid, cmd, point_index, entry_i, entry_q, full_scale,
      input  ready
   );

   modport sink (
      input  valid, cmd, point_index, entry_i, entry_q, full_scale,
      output ready
   );
endinterface

[src/cps_rsp_if.sv]
// Response channel of the constellation point scaler: valid/ready and one result.
// Depends on cps_pkg for the field widths.
interface cps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cps_pkg::DATA_W-1:0]  out_i;
   logic signed [cps_pkg::DATA_W-1:0]  out_q;
   logic [cps_pkg::STATUS_W-1:0]       status;
   logic                               saturated;

   modport source (
      output valid, out_i, out_q, status, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_i, out_q, status, saturated,
      output ready
   );
endinterface

[src/cps_ctrl.sv]
// Sequencer of the constellation point scaler: decodes each request and steps
// the datapath through table scan, square root and the two divisions. Uses cps_pkg.
module cps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cps_pkg::dp_stat_type stat,
   output cps_pkg::dp_cmd_type  ctl
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_SQI,
      S_SCAN_SQQ,
      S_SCAN_ACC,
      S_SQRT_INIT,
      S_SQRT_STEP,
      S_AMP,
      S_MAP_RD,
      S_MUL_I,
      S_DIV_I_LOAD,
      S_DIV_I,
      S_DIV_Q_LOAD,
      S_DIV_Q,
      S_STORE_Q,
      S_RESULT
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   cps_pkg::status_type code_ff;
   cps_pkg::status_type code_in;

   // Next state and the command word for the datapath.
   always_comb begin
      ctl            = '0;
      ctl.out_status = code_ff;
      state_in       = state_ff;
      code_in        = code_ff;
      case (state_ff)
         S_IDLE: begin
            ctl.in_ready = 1'b1;
            if (in_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               cps_pkg::CMD_WRITE: begin
                  if (stat.idx_in_table) begin
                     ctl.tbl_write = 1'b1;
                     code_in       = cps_pkg::ST_OK;
                  end else begin
                     code_in = cps_pkg::ST_BAD_INDEX;
                  end
                  state_in = S_RESULT;
               end
               cps_pkg::CMD_RECOMPUTE: begin
                  ctl.scan_clear = 1'b1;
                  code_in        = cps_pkg::ST_OK;
                  state_in       = stat.n_zero ? S_SQRT_INIT : S_SCAN_RD;
               end
               cps_pkg::CMD_MAP: begin
                  if (!stat.idx_lt_n) begin
                     code_in  = cps_pkg::ST_BAD_INDEX;
                     state_in = S_RESULT;
                  end else if (stat.amp_zero) begin
                     code_in  = cps_pkg::ST_ZERO_AMP;
                     state_in = S_RESULT;
                  end else begin
                     code_in  = cps_pkg::ST_OK;
                     state_in = S_MAP_RD;
                  end
               end
               default: begin
                  code_in  = cps_pkg::ST_OK;
                  state_in = S_RESULT;
               end
            endcase
         end
         // Energy scan: read, square I, square Q, accumulate and compare.
         S_SCAN_RD: begin
            ctl.rd_scan = 1'b1;
            state_in    = S_SCAN_SQI;
         end
         S_SCAN_SQI: begin
            ctl.mul_sel = cps_pkg::MUL_SQ_I;
            state_in    = S_SCAN_SQQ;
         end
         S_SCAN_SQQ: begin
            ctl.mul_sel  = cps_pkg::MUL_SQ_Q;
            ctl.acc_load = 1'b1;
            state_in     = S_SCAN_ACC;
         end
         S_SCAN_ACC: begin
            ctl.best_update = 1'b1;
            state_in        = stat.scan_done ? S_SQRT_INIT : S_SCAN_RD;
         end
         // Square root of the largest energy, two bits of operand per step.
         S_SQRT_INIT: begin
            ctl.sqrt_init = 1'b1;
            state_in      = S_SQRT_STEP;
         end
         S_SQRT_STEP: begin
            ctl.sqrt_step = 1'b1;
            if (stat.sqrt_last) begin
               state_in = S_AMP;
            end
         end
         S_AMP: begin
            ctl.amp_load = 1'b1;
            state_in     = S_RESULT;
         end
         // Map: fetch the point, then scale I and Q through the shared divider.
         S_MAP_RD: begin
            ctl.rd_idx = 1'b1;
            state_in   = S_MUL_I;
         end
         S_MUL_I: begin
            ctl.mul_sel = cps_pkg::MUL_FS_I;
            state_in    = S_DIV_I_LOAD;
         end
         S_DIV_I_LOAD: begin
            ctl.div_load = 1'b1;
            ctl.mul_sel  = cps_pkg::MUL_FS_Q;
            state_in     = S_DIV_I;
         end
         S_DIV_I: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DIV_Q_LOAD;
            end
         end
         S_DIV_Q_LOAD: begin
            ctl.store_i  = 1'b1;
            ctl.div_load = 1'b1;
            state_in     = S_DIV_Q;
         end
         S_DIV_Q: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_STORE_Q;
            end
         end
         S_STORE_Q: begin
            ctl.store_q = 1'b1;
            state_in    = S_RESULT;
         end
         // Hand the result to the output register once it has room.
         S_RESULT: begin
            if (stat.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and the registered status code.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= cps_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[src/cps_datapath.sv]
// Datapath of the constellation point scaler: point table, shared multiplier,
// square root and divider units, amplitude and the output register. Uses cps_pkg.
module cps_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               capture,
   input  logic [cps_pkg::CMD_W-1:0]          cmd,
   input  logic [cps_pkg::PIDX_W-1:0]         point_index,
   input  logic signed [cps_pkg::DATA_W-1:0]  entry_i,
   input  logic signed [cps_pkg::DATA_W-1:0]  entry_q,
   input  logic [cps_pkg::DATA_W-1:0]         full_scale,
   input  logic [cps_pkg::UP_W-1:0]           used_points,
   input  cps_pkg::dp_cmd_type                ctl,
   output cps_pkg::dp_stat_type               stat,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [cps_pkg::DATA_W-1:0]  out_i,
   output logic signed [cps_pkg::DATA_W-1:0]  out_q,
   output logic [cps_pkg::STATUS_W-1:0]       status,
   output logic                               saturated
);

   // Captured request.
   cps_pkg::cmd_type              cmd_ff;
   logic [cps_pkg::PIDX_W-1:0]    idx_ff;
   logic [cps_pkg::DATA_W-1:0]    ent_i_ff;
   logic [cps_pkg::DATA_W-1:0]    ent_q_ff;
   logic [cps_pkg::DATA_W-1:0]    fs_ff;

   // Point table with a valid bit per entry; an unwritten entry reads as zero.
   logic [cps_pkg::DATA_W-1:0]     mem_i [cps_pkg::MAX_POINTS];
   logic [cps_pkg::DATA_W-1:0]     mem_q [cps_pkg::MAX_POINTS];
   logic [cps_pkg::MAX_POINTS-1:0] vld_ff;
   logic [cps_pkg::DATA_W-1:0]     rd_i_ff;
   logic [cps_pkg::DATA_W-1:0]     rd_q_ff;
   logic                           rd_vld_ff;
   logic [cps_pkg::IDX_W-1:0]      rd_addr;
   logic [cps_pkg::IDX_W-1:0]      wr_addr;

   // Scan, multiplier, square root and divider registers.
   logic [cps_pkg::CNT_W-1:0]      k_ff;
   logic [cps_pkg::CNT_W-1:0]      n_cnt;
   logic [cps_pkg::WIDE_W-1:0]     prod_ff;
   logic [cps_pkg::WIDE_W-1:0]     prod_in;
   logic [cps_pkg::WIDE_W-1:0]     acc_ff;
   logic [cps_pkg::WIDE_W-1:0]     best_ff;
   logic [cps_pkg::WIDE_W-1:0]     energy_in;
   logic [cps_pkg::WIDE_W-1:0]     v_ff;
   logic [cps_pkg::WIDE_W-1:0]     root_ff;
   logic [cps_pkg::WIDE_W-1:0]     bit_ff;
   logic [cps_pkg::WIDE_W-1:0]     trial_in;
   logic [cps_pkg::DATA_W-1:0]     amp_ff;
   logic [cps_pkg::DATA_W-1:0]     rem_ff;
   logic [cps_pkg::DATA_W-1:0]     dq_ff;
   logic [cps_pkg::DATA_W:0]       rem_in;
   logic                           ovf_ff;
   logic [cps_pkg::DSTEP_W-1:0]    dcnt_ff;

   // Operands of the shared multiplier.
   logic [cps_pkg::DATA_W-1:0]     eff_i;
   logic [cps_pkg::DATA_W-1:0]     eff_q;
   logic [cps_pkg::DATA_W-1:0]     mag_i;
   logic [cps_pkg::DATA_W-1:0]     mag_q;
   logic [cps_pkg::DATA_W-1:0]     op_a;
   logic [cps_pkg::DATA_W-1:0]     op_b;

   // Scaled results and the output register.
   logic [cps_pkg::DATA_W-1:0]     res_i_ff;
   logic [cps_pkg::DATA_W-1:0]     res_q_ff;
   logic                           clip_ff;
   logic [cps_pkg::DATA_W:0]       sat_i_in;
   logic [cps_pkg::DATA_W:0]       sat_q_in;
   logic                           rsp_valid_ff;
   logic [cps_pkg::DATA_W-1:0]     out_i_ff;
   logic [cps_pkg::DATA_W-1:0]     out_q_ff;
   cps_pkg::status_type            out_status_ff;
   logic                           sat_ff;

   // Turns a quotient magnitude into a saturated signed value; the top bit is the clip flag.
   function automatic logic [cps_pkg::DATA_W:0] saturate(
      input logic                        neg,
      input logic                        ovf,
      input logic [cps_pkg::DATA_W-1:0]  qm
   );
      logic [cps_pkg::DATA_W:0] r;
      if (!neg) begin
         if (ovf || (qm > cps_pkg::POS_LIMIT)) begin
            r = {1'b1, cps_pkg::POS_LIMIT};
         end else begin
            r = {1'b0, qm};
         end
      end else begin
         if (ovf || (qm > cps_pkg::NEG_LIMIT)) begin
            r = {1'b1, cps_pkg::NEG_LIMIT};
         end else begin
            r = {1'b0, ~qm + 1'b1};
         end
      end
      return r;
   endfunction

   // Points in use, limited to the table size.
   always_comb begin
      if (cps_pkg::CMP_W'(used_points) > cps_pkg::CMP_W'(cps_pkg::MAX_POINTS)) begin
         n_cnt = cps_pkg::CNT_W'(cps_pkg::MAX_POINTS);
      end else begin
         n_cnt = cps_pkg::CNT_W'(used_points);
      end
   end

   // Request capture; results start at zero for every item.
   always_ff @(posedge clock) begin
      if (capture) begin
         cmd_ff   <= cps_pkg::cmd_type'(cmd);
         idx_ff   <= point_index;
         ent_i_ff <= entry_i;
         ent_q_ff <= entry_q;
         fs_ff    <= full_scale;
      end
   end

   assign wr_addr = idx_ff[cps_pkg::IDX_W-1:0];
   assign rd_addr = ctl.rd_scan ? k_ff[cps_pkg::IDX_W-1:0] : idx_ff[cps_pkg::IDX_W-1:0];

   // Table storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.tbl_write) begin
         mem_i[wr_addr] <= ent_i_ff;
         mem_q[wr_addr] <= ent_q_ff;
      end
      if (ctl.rd_scan || ctl.rd_idx) begin
         rd_i_ff <= mem_i[rd_addr];
         rd_q_ff <= mem_q[rd_addr];
      end
   end

   // Valid bits mark entries written since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.tbl_write) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_scan || ctl.rd_idx) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // Magnitudes of the fetched point; the sign stays in the raw value.
   assign eff_i = rd_vld_ff ? rd_i_ff : '0;
   assign eff_q = rd_vld_ff ? rd_q_ff : '0;
   assign mag_i = eff_i[cps_pkg::DATA_W-1] ? (~eff_i + 1'b1) : eff_i;
   assign mag_q = eff_q[cps_pkg::DATA_W-1] ? (~eff_q + 1'b1) : eff_q;

   // Shared 16 x 16 unsigned multiplier.
   always_comb begin
      case (ctl.mul_sel)
         cps_pkg::MUL_SQ_I: begin
            op_a = mag_i;
            op_b = mag_i;
         end
         cps_pkg::MUL_SQ_Q: begin
            op_a = mag_q;
            op_b = mag_q;
         end
         cps_pkg::MUL_FS_I: begin
            op_a = mag_i;
            op_b = fs_ff;
         end
         cps_pkg::MUL_FS_Q: begin
            op_a = mag_q;
            op_b = fs_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in   = {{cps_pkg::DATA_W{1'b0}}, op_a} * {{cps_pkg::DATA_W{1'b0}}, op_b};
   assign energy_in = acc_ff + prod_ff;

   // Product register and the running maximum of the point energies.
   always_ff @(posedge clock) begin
      if (ctl.mul_sel != cps_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_load) begin
         acc_ff <= prod_ff;
      end
      if (ctl.scan_clear) begin
         best_ff <= '0;
      end else if (ctl.best_update && (energy_in > best_ff)) begin
         best_ff <= energy_in;
      end
   end

   // Scan counter over the points in use.
   always_ff @(posedge clock) begin
      if (ctl.scan_clear) begin
         k_ff <= '0;
      end else if (ctl.rd_scan) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // Bitwise square root: one result bit per step.
   assign trial_in = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (ctl.sqrt_init) begin
         v_ff    <= best_ff;
         root_ff <= '0;
         bit_ff  <= cps_pkg::SQRT_FIRST_BIT;
      end else if (ctl.sqrt_step) begin
         if (v_ff >= trial_in) begin
            v_ff    <= v_ff - trial_in;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Amplitude register.
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '0;
      end else if (ctl.amp_load) begin
         amp_ff <= root_ff[cps_pkg::DATA_W-1:0];
      end
   end

   // Restoring divider. A high half not below the amplitude means a quotient
   // of at least 2^16, which always saturates.
   assign rem_in = {rem_ff, dq_ff[cps_pkg::DATA_W-1]};

   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         rem_ff  <= prod_ff[cps_pkg::WIDE_W-1:cps_pkg::DATA_W];
         dq_ff   <= prod_ff[cps_pkg::DATA_W-1:0];
         ovf_ff  <= prod_ff[cps_pkg::WIDE_W-1:cps_pkg::DATA_W] >= amp_ff;
         dcnt_ff <= '0;
      end else if (ctl.div_step) begin
         if (rem_in >= {1'b0, amp_ff}) begin
            rem_ff <= cps_pkg::DATA_W'(rem_in - {1'b0, amp_ff});
            dq_ff  <= {dq_ff[cps_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_in[cps_pkg::DATA_W-1:0];
            dq_ff  <= {dq_ff[cps_pkg::DATA_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // Signed, saturated scaled values.
   assign sat_i_in = saturate(eff_i[cps_pkg::DATA_W-1], ovf_ff, dq_ff);
   assign sat_q_in = saturate(eff_q[cps_pkg::DATA_W-1], ovf_ff, dq_ff);

   always_ff @(posedge clock) begin
      if (capture) begin
         res_i_ff <= '0;
         res_q_ff <= '0;
         clip_ff  <= 1'b0;
      end else begin
         if (ctl.store_i) begin
            res_i_ff <= sat_i_in[cps_pkg::DATA_W-1:0];
            clip_ff  <= clip_ff | sat_i_in[cps_pkg::DATA_W];
         end
         if (ctl.store_q) begin
            res_q_ff <= sat_q_in[cps_pkg::DATA_W-1:0];
            clip_ff  <= clip_ff | sat_q_in[cps_pkg::DATA_W];
         end
      end
   end

   // Output register: holds a finished beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         out_i_ff      <= res_i_ff;
         out_q_ff      <= res_q_ff;
         out_status_ff <= ctl.out_status;
         sat_ff        <= clip_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_i     = out_i_ff;
   assign out_q     = out_q_ff;
   assign status    = out_status_ff;
   assign saturated = sat_ff;

   // Status back to the controller.
   always_comb begin
      stat              = '0;
      stat.cmd          = cmd_ff;
      stat.idx_in_table = cps_pkg::CMP_W'(idx_ff) < cps_pkg::CMP_W'(cps_pkg::MAX_POINTS);
      stat.idx_lt_n     = cps_pkg::CMP_W'(idx_ff) < cps_pkg::CMP_W'(n_cnt);
      stat.amp_zero     = (amp_ff == '0);
      stat.n_zero       = (n_cnt == '0);
      stat.scan_done    = (k_ff == n_cnt);
      stat.sqrt_last    = bit_ff[0];
      stat.div_last     = (dcnt_ff == cps_pkg::DSTEP_W'(cps_pkg::DIV_STEPS - 1));
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // A result is never loaded over a beat that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   // The divider only runs against a nonzero amplitude.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> (amp_ff != '0))
      else $error("division step with zero amplitude");

   // The square root always fits the amplitude register.
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      ctl.amp_load |-> (root_ff[cps_pkg::WIDE_W-1:cps_pkg::DATA_W] == '0))
      else $error("square root wider than the amplitude");

   // Only a successful map carries nonzero values or a clip flag.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (ctl.out_load && (ctl.out_status != cps_pkg::ST_OK))
         |-> (res_i_ff == '0 && res_q_ff == '0 && !clip_ff))
      else $error("error result with nonzero payload");

   // Table writes stay inside the table.
   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      ctl.tbl_write |-> (cps_pkg::CMP_W'(idx_ff) < cps_pkg::CMP_W'(cps_pkg::MAX_POINTS)))
      else $error("table write outside the table");

endmodule

[src/constellation_point_scaler.sv]
// Constellation point scaler: one request is worked on at a time, and the next
// one is taken as soon as the previous result sits in the output register, even
// while that beat still waits for the consumer. A map runs the shared restoring
// divider, which gives one quotient bit per cycle, once for I and once for Q. A
// recompute is paced by the single table read port and the shared multiplier in
// the energy scan and by the 16-step square root. Register 0 (byte address 0)
// holds used_points; the table and the amplitude are zero after reset, with no
// clearing pass.
// Top level; depends on cps_pkg, cps_req_if, cps_rsp_if, cps_ctrl, cps_datapath.
module constellation_point_scaler (
   input  logic                          clock,
   input  logic                          reset,
   cps_req_if.sink                       req,
   cps_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cps_pkg::PADDR_W-1:0]   paddr,
   input  logic [cps_pkg::PDATA_W-1:0]   pwdata,
   output logic [cps_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   logic                         used_points_ff;
   logic [cps_pkg::UP_W-1:0]     used_pts_ff;
   logic                         reg_wr;
   logic                         reg_sel;
   logic                         capture;
   cps_pkg::dp_cmd_type          ctl;
   cps_pkg::dp_stat_type         stat;

   // Register port: writes land in the access phase, reads are immediate.
   assign pready  = 1'b1;
   assign reg_sel = (paddr[cps_pkg::PADDR_W-1:2] == cps_pkg::REG_USED_POINTS);
   assign reg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_pts_ff    <= '0;
         used_points_ff <= 1'b0;
      end else if (reg_wr && reg_sel) begin
         used_pts_ff    <= pwdata[cps_pkg::UP_W-1:0];
         used_points_ff <= (pwdata[cps_pkg::UP_W-1:0] != '0);
      end
   end

   assign prdata = (reg_sel && (used_points_ff || (used_pts_ff != '0)))
                   ? cps_pkg::PDATA_W'(used_pts_ff) : '0;

   // Request handshake.
   assign req.ready = ctl.in_ready;
   assign capture   = req.valid && req.ready;

   cps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .stat     (stat),
      .ctl      (ctl)
   );

   cps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .capture     (capture),
      .cmd         (req.cmd),
      .point_index (req.point_index),
      .entry_i     (req.entry_i),
      .entry_q     (req.entry_q),
      .full_scale  (req.full_scale),
      .used_points (used_pts_ff),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_ready   (rsp.ready),
      .rsp_valid   (rsp.valid),
      .out_i       (rsp.out_i),
      .out_q       (rsp.out_q),
      .status      (rsp.status),
      .saturated   (rsp.saturated)
   );

endmodule
